// File: hw/rtl/nec_pkg.sv
package nec_pkg;

  // field and burst geometry
  localparam int FIELD_BITS     = 16;
  localparam int POS_W          = $clog2(FIELD_BITS);
  localparam int FRAME_SYMBOLS  = 34;
  localparam int REPEAT_SYMBOLS = 2;
  localparam int MAX_SYMBOLS    = 64;
  localparam int TIME_W         = 15;
  localparam int MARGIN_W       = 9;
  localparam int CFG_INDEX_W    = 3;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MARGIN       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LEADER_MARK  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LEADER_SPACE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BIT_MARK     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_SPACE   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ONE_SPACE    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_SPACE = 3'd6;

  // configuration reset values
  localparam logic [MARGIN_W-1:0] MARGIN_RST       = 9'd200;
  localparam logic [TIME_W-1:0]   LEADER_MARK_RST  = 15'd9000;
  localparam logic [TIME_W-1:0]   LEADER_SPACE_RST = 15'd4500;
  localparam logic [TIME_W-1:0]   BIT_MARK_RST     = 15'd560;
  localparam logic [TIME_W-1:0]   ZERO_SPACE_RST   = 15'd560;
  localparam logic [TIME_W-1:0]   ONE_SPACE_RST    = 15'd1690;
  localparam logic [TIME_W-1:0]   REPEAT_SPACE_RST = 15'd2250;

  // status codes
  localparam logic [1:0] STATUS_INVALID = 2'd0;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd1;
  localparam logic [1:0] STATUS_REPEAT  = 2'd2;
  localparam logic [1:0] STATUS_FRAME   = 2'd3;

  typedef struct packed {
    logic [TIME_W-1:0] mark_time;
    logic [TIME_W-1:0] space_time;
    logic              burst_end;
  } symbol_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [FIELD_BITS-1:0] address;
    logic [FIELD_BITS-1:0] command;
  } result_t;

endpackage

// File: hw/rtl/nec_ir_frame_decoder.sv
// latency: a result appears in the cycle after the beat carrying burst_end is accepted
// throughput: one symbol per cycle while no result is stalled; output frees in the same cycle it is taken
// symbols that are not the end of a burst update the burst state only and give no result
// reset (rst, synchronous): timing registers to nominal NEC values, burst state cleared,
// stored address and command zero, no result pending
module nec_ir_frame_decoder #(
  parameter int MAX_SYMBOLS = nec_pkg::MAX_SYMBOLS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  nec_pkg::symbol_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output nec_pkg::result_t                 out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [nec_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [nec_pkg::TIME_W-1:0]       cfg_data
);

  localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
  localparam int FW    = nec_pkg::FIELD_BITS;
  localparam int TW    = nec_pkg::TIME_W;
  localparam int MW    = nec_pkg::MARGIN_W;

  // duration check, strictly inside nominal +/- margin, signed bounds
  function automatic logic near(logic [TW-1:0] m, logic [TW-1:0] n, logic [MW-1:0] d);
    logic signed [TW+1:0] ms;
    logic signed [TW+1:0] hi;
    logic signed [TW+1:0] lo;
    ms = signed'({2'b00, m});
    hi = signed'({2'b00, n}) + signed'({{(TW+2-MW){1'b0}}, d});
    lo = signed'({2'b00, n}) - signed'({{(TW+2-MW){1'b0}}, d});
    return (ms < hi) && (ms > lo);
  endfunction

  // configuration registers
  logic [MW-1:0] margin;
  logic [TW-1:0] leader_mark;
  logic [TW-1:0] leader_space;
  logic [TW-1:0] bit_mark;
  logic [TW-1:0] zero_space;
  logic [TW-1:0] one_space;
  logic [TW-1:0] repeat_space;

  // burst state
  logic [CNT_W-1:0] symbol_count;
  logic [FW-1:0]    address_shift;
  logic [FW-1:0]    command_shift;
  logic             burst_ok;
  logic             first_is_repeat;
  logic [FW-1:0]    saved_address;
  logic [FW-1:0]    saved_command;

  logic [CNT_W-1:0] symbol_count_next;
  logic [FW-1:0]    address_shift_next;
  logic [FW-1:0]    command_shift_next;
  logic             burst_ok_next;
  logic             first_is_repeat_next;
  logic [FW-1:0]    saved_address_next;
  logic [FW-1:0]    saved_command_next;
  logic [1:0]       status_next;

  logic             in_fire;
  logic [CNT_W-1:0] idx_m1;
  logic [nec_pkg::POS_W-1:0] bit_pos;
  logic             mark_ok;
  logic             is_one;
  logic             is_zero;
  logic             leader_ok;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      margin       <= nec_pkg::MARGIN_RST;
      leader_mark  <= nec_pkg::LEADER_MARK_RST;
      leader_space <= nec_pkg::LEADER_SPACE_RST;
      bit_mark     <= nec_pkg::BIT_MARK_RST;
      zero_space   <= nec_pkg::ZERO_SPACE_RST;
      one_space    <= nec_pkg::ONE_SPACE_RST;
      repeat_space <= nec_pkg::REPEAT_SPACE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        nec_pkg::REG_MARGIN:       margin       <= cfg_data[MW-1:0];
        nec_pkg::REG_LEADER_MARK:  leader_mark  <= cfg_data;
        nec_pkg::REG_LEADER_SPACE: leader_space <= cfg_data;
        nec_pkg::REG_BIT_MARK:     bit_mark     <= cfg_data;
        nec_pkg::REG_ZERO_SPACE:   zero_space   <= cfg_data;
        nec_pkg::REG_ONE_SPACE:    one_space    <= cfg_data;
        nec_pkg::REG_REPEAT_SPACE: repeat_space <= cfg_data;
        default: ;
      endcase
    end
  end

  // symbol classification
  assign idx_m1    = symbol_count - CNT_W'(1);
  assign bit_pos   = idx_m1[nec_pkg::POS_W-1:0];
  assign mark_ok   = near(in_data.mark_time, bit_mark, margin);
  assign is_one    = mark_ok && near(in_data.space_time, one_space, margin);
  assign is_zero   = mark_ok && near(in_data.space_time, zero_space, margin);
  assign leader_ok = near(in_data.mark_time, leader_mark, margin);

  // burst state update and end-of-burst verdict
  always_comb begin
    symbol_count_next    = symbol_count;
    address_shift_next   = address_shift;
    command_shift_next   = command_shift;
    burst_ok_next        = burst_ok;
    first_is_repeat_next = first_is_repeat;
    saved_address_next   = saved_address;
    saved_command_next   = saved_command;
    status_next          = nec_pkg::STATUS_UNKNOWN;

    if (symbol_count < CNT_W'(MAX_SYMBOLS)) begin
      if (symbol_count == '0) begin
        if (!(leader_ok && near(in_data.space_time, leader_space, margin))) begin
          burst_ok_next = 1'b0;
        end
        first_is_repeat_next = leader_ok && near(in_data.space_time, repeat_space, margin);
      end else if (symbol_count <= CNT_W'(2 * FW)) begin
        if (is_one || is_zero) begin
          if (symbol_count <= CNT_W'(FW)) begin
            address_shift_next[bit_pos] = is_one;
          end else begin
            command_shift_next[bit_pos] = is_one;
          end
        end else begin
          burst_ok_next = 1'b0;
        end
      end
      symbol_count_next = symbol_count + CNT_W'(1);
    end

    if (symbol_count_next == CNT_W'(nec_pkg::FRAME_SYMBOLS)) begin
      if (burst_ok_next) begin
        saved_address_next = address_shift_next;
        saved_command_next = command_shift_next;
        status_next        = nec_pkg::STATUS_FRAME;
      end else begin
        status_next = nec_pkg::STATUS_INVALID;
      end
    end else if (symbol_count_next == CNT_W'(nec_pkg::REPEAT_SYMBOLS)) begin
      status_next = first_is_repeat_next ? nec_pkg::STATUS_REPEAT : nec_pkg::STATUS_INVALID;
    end
  end

  // burst registers, cleared after the last symbol of each burst, apart from the saved address and command
  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_count    <= '0;
      address_shift   <= '0;
      command_shift   <= '0;
      burst_ok        <= 1'b1;
      first_is_repeat <= 1'b0;
      saved_address   <= '0;
      saved_command   <= '0;
    end else if (in_fire) begin
      if (in_data.burst_end) begin
        symbol_count    <= '0;
        address_shift   <= '0;
        command_shift   <= '0;
        burst_ok        <= 1'b1;
        first_is_repeat <= 1'b0;
        saved_address   <= saved_address_next;
        saved_command   <= saved_command_next;
      end else begin
        symbol_count    <= symbol_count_next;
        address_shift   <= address_shift_next;
        command_shift   <= command_shift_next;
        burst_ok        <= burst_ok_next;
        first_is_repeat <= first_is_repeat_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && in_data.burst_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_data.burst_end) begin
      out_data.status  <= status_next;
      out_data.address <= saved_address_next;
      out_data.command <= saved_command_next;
    end
  end

endmodule
